[src/tcw_pkg.sv]
// tcw_pkg: request and result types, command codes and character constants
// for the text console writer; no dependencies
package tcw_pkg;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in;

    typedef struct packed {
        logic [4:0] cursor_row_out;
        logic [6:0] cursor_col_out;
        logic [7:0] cell_char;
        logic [7:0] cell_color;
    } t_out;

    typedef logic [2:0] t_op;

    localparam t_op OP_NOP       = 3'd0;
    localparam t_op OP_PUT       = 3'd1;
    localparam t_op OP_BACKSPACE = 3'd2;
    localparam t_op OP_NEWLINE   = 3'd3;
    localparam t_op OP_CLEAR     = 3'd4;
    localparam t_op OP_READ      = 3'd5;

    typedef struct packed {
        t_op        op;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_cmd;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [7:0] CHAR_BACKSPACE   = 8'd8;
    localparam logic [7:0] CHAR_NEWLINE     = 8'd10;
    localparam logic [7:0] CHAR_BLANK       = 8'd32;
    localparam logic [7:0] TEXT_COLOR_RESET = 8'd15;

    localparam int CELL_W = 16;

endpackage

[src/tcw_ram.sv]
// tcw_ram: generic single write port, single read port ram with registered read
// no dependencies
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/tcw_front.sv]
// tcw_front: accepts requests, decodes them into commands and holds them in a
// two-entry queue for the back end; depends on tcw_pkg
module tcw_front #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_open,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tcw_pkg::t_in  i_in_data,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output tcw_pkg::t_cmd o_cmd
);

    tcw_pkg::t_cmd w_cmd;
    tcw_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          n_wp;
    logic          n_rp;
    logic [1:0]    n_cnt;
    logic          w_push;
    logic          w_pop;

    // decode
    always_comb begin
        w_cmd.char_code = i_in_data.char_code;
        w_cmd.read_row  = i_in_data.read_row;
        w_cmd.read_col  = i_in_data.read_col;
        case (i_in_data.func)
            tcw_pkg::FUNC_PUT: begin
                if (i_in_data.char_code == tcw_pkg::CHAR_BACKSPACE) begin
                    w_cmd.op = tcw_pkg::OP_BACKSPACE;
                end else if (i_in_data.char_code == tcw_pkg::CHAR_NEWLINE) begin
                    w_cmd.op = tcw_pkg::OP_NEWLINE;
                end else begin
                    w_cmd.op = tcw_pkg::OP_PUT;
                end
            end
            tcw_pkg::FUNC_CLEAR: begin
                w_cmd.op = tcw_pkg::OP_CLEAR;
            end
            tcw_pkg::FUNC_READ: begin
                if (32'(i_in_data.read_row) < 32'(SCREEN_ROWS) &&
                    32'(i_in_data.read_col) < 32'(SCREEN_COLS)) begin
                    w_cmd.op = tcw_pkg::OP_READ;
                end else begin
                    w_cmd.op = tcw_pkg::OP_NOP;
                end
            end
            default: begin
                w_cmd.op = tcw_pkg::OP_NOP;
            end
        endcase
    end

    assign o_in_ready  = i_open && (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = w_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("queue count out of range");
`endif

endmodule

[src/tcw_back.sv]
// tcw_back: executes commands against the cell store, keeps cursor, scroll
// offset and color, and registers the result; depends on tcw_pkg, tcw_ram
module tcw_back #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  tcw_pkg::t_cmd i_cmd,
    output logic          o_open,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tcw_pkg::t_out o_out_data
);

    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int COL_W  = $clog2(SCREEN_COLS + 1);
    localparam int CIDX_W = $clog2(SCREEN_COLS);
    localparam int CELLS  = SCREEN_ROWS * SCREEN_COLS;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [ROW_W:0]    ROWS_C    = (ROW_W + 1)'(SCREEN_ROWS);
    localparam logic [COL_W-1:0]  COLS_C    = COL_W'(SCREEN_COLS);
    localparam logic [CIDX_W-1:0] LAST_COL  = CIDX_W'(SCREEN_COLS - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLS);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_ROW  = 3'd2;
    localparam logic [2:0] S_ALL  = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;

    logic [2:0]                  r_state, n_state;
    logic [ROW_W-1:0]            r_row, n_row;
    logic [COL_W-1:0]            r_col, n_col;
    logic [ROW_W-1:0]            r_top, n_top;
    logic [7:0]                  r_color, n_color;
    logic [ADDR_W-1:0]           r_lin, n_lin;
    logic [CIDX_W-1:0]           r_scol, n_scol;
    logic [ADDR_W-1:0]           r_base, n_base;
    logic                        r_put_after, n_put_after;
    logic [7:0]                  r_char, n_char;
    logic                        r_out_valid, n_out_valid;
    tcw_pkg::t_out               r_out, n_out;

    logic [ROW_W-1:0]            w_arow;
    logic [CIDX_W-1:0]           w_acol;
    logic [ROW_W:0]              w_phys_sum;
    logic [ROW_W-1:0]            w_phys;
    logic [ADDR_W-1:0]           w_row_base;
    logic [ADDR_W-1:0]           w_addr;
    logic                        w_wrap;
    logic                        w_last;
    logic                        w_pop;
    logic                        w_load;
    logic [tcw_pkg::CELL_W-1:0]  w_cell;
    logic [tcw_pkg::CELL_W-1:0]  w_blank;
    logic [ROW_W-1:0]            w_top_inc;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
    logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

    assign w_wrap    = (r_col == COLS_C);
    assign w_last    = (r_row == LAST_ROW);
    assign w_blank   = {r_color, tcw_pkg::CHAR_BLANK};
    assign w_top_inc = (r_top == LAST_ROW) ? '0 : ROW_W'(r_top + 1'b1);

    assign o_cmd_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign o_open      = (r_state != S_INIT);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // logical cell of the command
    always_comb begin
        w_arow = '0;
        w_acol = '0;
        case (i_cmd.op)
            tcw_pkg::OP_BACKSPACE: begin
                w_arow = r_row;
                w_acol = CIDX_W'(r_col - 1'b1);
            end
            tcw_pkg::OP_PUT: begin
                if (w_wrap) begin
                    w_arow = w_last ? '0 : ROW_W'(r_row + 1'b1);
                end else begin
                    w_arow = r_row;
                    w_acol = CIDX_W'(r_col);
                end
            end
            tcw_pkg::OP_READ: begin
                w_arow = ROW_W'(i_cmd.read_row);
                w_acol = CIDX_W'(i_cmd.read_col);
            end
            default: begin
                w_arow = '0;
                w_acol = '0;
            end
        endcase
    end

    // rotate by scroll offset into a physical row
    assign w_phys_sum = {1'b0, w_arow} + {1'b0, r_top};
    assign w_phys     = (w_phys_sum >= ROWS_C) ? ROW_W'(w_phys_sum - ROWS_C)
                                               : ROW_W'(w_phys_sum);
    assign w_row_base = ADDR_W'(w_phys) * COLS_A;
    assign w_addr     = w_row_base + ADDR_W'(w_acol);

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_top       = r_top;
        n_color     = i_cfg_we ? i_cfg_data : r_color;
        n_lin       = r_lin;
        n_scol      = r_scol;
        n_base      = r_base;
        n_put_after = r_put_after;
        n_char      = r_char;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_load      = 1'b0;
        w_cell      = '0;
        ram_we      = 1'b0;
        ram_waddr   = w_addr;
        ram_wdata   = w_blank;

        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_lin;
                ram_wdata = '0;
                n_lin     = ADDR_W'(r_lin + 1'b1);
                if (r_lin == LAST_ADDR) begin
                    n_lin   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_pop) begin
                    case (i_cmd.op)
                        tcw_pkg::OP_PUT: begin
                            if (w_wrap && w_last) begin
                                n_top       = w_top_inc;
                                n_base      = w_row_base;
                                n_scol      = '0;
                                n_put_after = 1'b1;
                                n_char      = i_cmd.char_code;
                                n_col       = COL_W'(1);
                                n_state     = S_ROW;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = {r_color, i_cmd.char_code};
                                if (w_wrap) begin
                                    n_row = ROW_W'(r_row + 1'b1);
                                    n_col = COL_W'(1);
                                end else begin
                                    n_col = COL_W'(r_col + 1'b1);
                                end
                                w_load = 1'b1;
                            end
                        end
                        tcw_pkg::OP_BACKSPACE: begin
                            if (r_col != '0) begin
                                ram_we = 1'b1;
                                n_col  = COL_W'(r_col - 1'b1);
                            end
                            w_load = 1'b1;
                        end
                        tcw_pkg::OP_NEWLINE: begin
                            n_col = '0;
                            if (!w_last) begin
                                n_row  = ROW_W'(r_row + 1'b1);
                                w_load = 1'b1;
                            end else begin
                                n_top       = w_top_inc;
                                n_base      = w_row_base;
                                n_scol      = '0;
                                n_put_after = 1'b0;
                                n_state     = S_ROW;
                            end
                        end
                        tcw_pkg::OP_CLEAR: begin
                            n_lin   = '0;
                            n_state = S_ALL;
                        end
                        tcw_pkg::OP_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            S_ROW: begin
                ram_we    = 1'b1;
                ram_waddr = r_base + ADDR_W'(r_scol);
                if (r_scol == '0 && r_put_after) begin
                    ram_wdata = {r_color, r_char};
                end
                n_scol = CIDX_W'(r_scol + 1'b1);
                if (r_scol == LAST_COL) begin
                    n_state = S_IDLE;
                    w_load  = 1'b1;
                end
            end
            S_ALL: begin
                ram_we    = 1'b1;
                ram_waddr = r_lin;
                n_lin     = ADDR_W'(r_lin + 1'b1);
                if (r_lin == LAST_ADDR) begin
                    n_lin   = '0;
                    n_state = S_IDLE;
                    w_load  = 1'b1;
                end
            end
            S_READ: begin
                w_cell  = ram_rdata;
                n_state = S_IDLE;
                w_load  = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_load) begin
            n_out_valid          = 1'b1;
            n_out.cursor_row_out = 5'(n_row);
            n_out.cursor_col_out = 7'(n_col);
            n_out.cell_char      = w_cell[7:0];
            n_out.cell_color     = w_cell[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_top       <= '0;
            r_color     <= tcw_pkg::TEXT_COLOR_RESET;
            r_lin       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_top       <= n_top;
            r_color     <= n_color;
            r_lin       <= n_lin;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scol      <= n_scol;
        r_base      <= n_base;
        r_put_after <= n_put_after;
        r_char      <= n_char;
        r_out       <= n_out;
    end

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (w_addr),
        .o_rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COLS_C)
        else $error("cursor column beyond wrap position");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= LAST_ROW && r_top <= LAST_ROW)
        else $error("cursor row or scroll offset out of range");

    a_read_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_cmd.op == tcw_pkg::OP_READ) |=> (r_state == S_READ))
        else $error("read request did not wait for cell data");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_out_valid && r_state == S_IDLE))
        else $error("read result not registered");

    a_busy_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_cmd_ready)
        else $error("request taken while a sweep is running");
`endif

endmodule

[src/text_console_writer_unit.sv]
// text_console_writer_unit: top level of the text console writer
// depends on tcw_pkg, tcw_front, tcw_back, tcw_ram
//
// After reset the cell store is swept to zero, one cell per cycle, over all
// SCREEN_ROWS*SCREEN_COLS cells (2000 by default); no request is taken
// meanwhile, color writes are. The front end then queues up to two requests
// while the back end works. Put, backspace, in-row newline and reads outside
// the screen finish without leaving the idle state; an in-range read waits in
// a read state for the registered ram read; a newline or wrap on the last row
// scrolls by moving the top-row offset and blanking one row; clear blanks
// every cell. Sweeps write one cell at a time through the store's single write port.
module text_console_writer_unit #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tcw_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tcw_pkg::t_out o_out_data
);

    logic          w_open;
    logic          w_cmd_valid;
    logic          w_cmd_ready;
    tcw_pkg::t_cmd w_cmd;

    tcw_front #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_open      (w_open),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    tcw_back #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_open      (w_open),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
